FILE: hdl/vnug_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnug_pkg
// Shared types and constants for the von Neumann UUID generator.
// ----------------------------------------------------------------------------
package vnug_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 4;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [COUNT_W-1:0] LAST_BIT     = 3'd7;
    localparam logic [INDEX_W-1:0] VERSION_BYTE = 4'd6;
    localparam logic [INDEX_W-1:0] VARIANT_BYTE = 4'd8;
    localparam logic [INDEX_W-1:0] FINAL_BYTE   = 4'd15;

    localparam logic [BYTE_W-1:0] VERSION_BITS = 8'h40;
    localparam logic [BYTE_W-1:0] VERSION_KEEP = 8'h0F;
    localparam logic [BYTE_W-1:0] VARIANT_BITS = 8'h80;
    localparam logic [BYTE_W-1:0] VARIANT_KEEP = 8'h3F;

    // A completed whitened byte, handed from the extractor to the formatter.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } byte_evt_t;

endpackage

FILE: hdl/vnug_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnug_extract
// Von Neumann pairing and MSB-first byte assembly.
// ----------------------------------------------------------------------------
module vnug_extract (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               fire,
    input  logic               raw_bit,
    output vnug_pkg::byte_evt_t evt,
    output logic               may_complete
);
    import vnug_pkg::*;

    logic               pair_pending_reg;
    logic               first_raw_reg;
    logic [BYTE_W-2:0]  byte_shift_reg;
    logic [COUNT_W-1:0] bit_count_reg;

    logic               white_valid;

    // A second bit that differs from the first yields a whitened bit.
    assign white_valid  = fire && pair_pending_reg && (first_raw_reg != raw_bit);
    assign may_complete = pair_pending_reg && (bit_count_reg == LAST_BIT);

    assign evt.valid = white_valid && (bit_count_reg == LAST_BIT);
    assign evt.data  = {byte_shift_reg, raw_bit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_pending_reg <= 1'b0;
            first_raw_reg    <= 1'b0;
            byte_shift_reg   <= '0;
            bit_count_reg    <= '0;
        end else if (fire) begin
            if (!pair_pending_reg) begin
                first_raw_reg    <= raw_bit;
                pair_pending_reg <= 1'b1;
            end else begin
                pair_pending_reg <= 1'b0;
                if (white_valid) begin
                    if (bit_count_reg == LAST_BIT) begin
                        byte_shift_reg <= '0;
                        bit_count_reg  <= '0;
                    end else begin
                        byte_shift_reg <= {byte_shift_reg[BYTE_W-3:0], raw_bit};
                        bit_count_reg  <= bit_count_reg + COUNT_W'(1);
                    end
                end
            end
        end
    end

endmodule

FILE: hdl/vnug_format.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnug_format
// UUID byte numbering, version/variant forcing and the result register.
// ----------------------------------------------------------------------------
module vnug_format (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_wr_data,
    input  vnug_pkg::byte_evt_t       evt,
    input  logic                      m_ready,
    output logic                      m_valid,
    output logic [vnug_pkg::BYTE_W-1:0]  m_out_byte,
    output logic [vnug_pkg::INDEX_W-1:0] m_byte_index,
    output logic                      m_last_byte,
    output logic                      uuid_mode
);
    import vnug_pkg::*;

    logic               uuid_mode_reg;
    logic [INDEX_W-1:0] position_reg;
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [INDEX_W-1:0] byte_index_reg;
    logic               last_byte_reg;

    logic [BYTE_W-1:0]  out_byte_next;
    logic [INDEX_W-1:0] byte_index_next;
    logic               last_byte_next;

    always_comb begin
        out_byte_next   = evt.data;
        byte_index_next = '0;
        last_byte_next  = 1'b1;
        if (uuid_mode_reg) begin
            byte_index_next = position_reg;
            last_byte_next  = (position_reg == FINAL_BYTE);
            if (position_reg == VERSION_BYTE) begin
                out_byte_next = VERSION_BITS | (evt.data & VERSION_KEEP);
            end else if (position_reg == VARIANT_BYTE) begin
                out_byte_next = VARIANT_BITS | (evt.data & VARIANT_KEEP);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            uuid_mode_reg <= 1'b1;
            position_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                uuid_mode_reg <= cfg_wr_data;
                position_reg  <= '0;
            end else if (evt.valid && uuid_mode_reg) begin
                position_reg <= position_reg + INDEX_W'(1);
            end
            if (evt.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt.valid) begin
            out_byte_reg   <= out_byte_next;
            byte_index_reg <= byte_index_next;
            last_byte_reg  <= last_byte_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_byte_index = byte_index_reg;
    assign m_last_byte  = last_byte_reg;
    assign uuid_mode    = uuid_mode_reg;

endmodule

FILE: hdl/von_neumann_uuid_generator.sv
`timescale 1ns / 1ps
// Takes one raw entropy bit per cycle while s_ready is high and emits von Neumann
// whitened bytes, either as plain bytes (index 0, last set) or as sixteen-byte
// version 4 UUIDs with the version nibble forced into byte 6 and the variant
// bits into byte 8. A finished byte is registered into the result register in
// the cycle after the raw bit that completes it is accepted. s_ready stays
// high while a byte waits on m_ready, and drops only for the one input word that
// could complete the next byte while the previous byte is still unread. Writing
// uuid_mode restarts UUID numbering at byte 0; bit pairing is not disturbed.
// ----------------------------------------------------------------------------
// von_neumann_uuid_generator
// Top level: input handshake, extractor, formatter and result channel.
// ----------------------------------------------------------------------------
module von_neumann_uuid_generator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_raw_bit,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [vnug_pkg::BYTE_W-1:0]  m_out_byte,
    output logic [vnug_pkg::INDEX_W-1:0] m_byte_index,
    output logic                         m_last_byte
);
    import vnug_pkg::*;

    byte_evt_t evt;
    logic      fire;
    logic      may_complete;
    logic      uuid_mode;

    // Hold the input only when this word could finish a byte and the result
    // register is still occupied.
    assign s_ready = !(may_complete && m_valid && !m_ready);
    assign fire    = s_valid && s_ready;

    vnug_extract u_extract (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .raw_bit      (s_raw_bit),
        .evt          (evt),
        .may_complete (may_complete)
    );

    vnug_format u_format (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .evt          (evt),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_byte_index (m_byte_index),
        .m_last_byte  (m_last_byte),
        .uuid_mode    (uuid_mode)
    );

    // A new byte never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        evt.valid |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // UUID byte 6 carries version 4.
    a_version: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && uuid_mode && m_byte_index == VERSION_BYTE)
            |-> (m_out_byte[7:4] == 4'h4))
        else $error("version nibble missing");

    // UUID byte 8 carries the variant bits.
    a_variant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && uuid_mode && m_byte_index == VARIANT_BYTE)
            |-> (m_out_byte[7:6] == 2'b10))
        else $error("variant bits missing");

    // Last flag follows the byte position.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (uuid_mode ? (m_last_byte == (m_byte_index == FINAL_BYTE))
                               : (m_last_byte && m_byte_index == '0)))
        else $error("last flag inconsistent with position");

endmodule

FILE: test/tb_von_neumann_uuid_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_von_neumann_uuid_generator
// Self-checking bench for the whitened byte and UUID generator. A scoreboard
// class tracks bit pairing, byte assembly and UUID numbering. Every raw word
// the block accepts goes into the scoreboard, and every result word is
// checked against the oldest prediction. Both modes are exercised, and
// uuid_mode is rewritten between phases. Idle bursts are random, one long
// receiver stall fills the block, and the final phases run without gaps.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [vnug_pkg::BYTE_W-1:0]  data;
    logic [vnug_pkg::INDEX_W-1:0] index;
    logic                         last;
} uuid_word_t;

class uuid_byte_scoreboard;
    uuid_word_t                   expected_words[$];
    bit                           uuid_mode;
    bit                           pair_pending;
    bit                           first_raw;
    bit [6:0]                     byte_shift;
    bit [vnug_pkg::COUNT_W-1:0]   bit_count;
    bit [vnug_pkg::INDEX_W-1:0]   uuid_position;
    int unsigned                  words_predicted;
    int unsigned                  words_checked;
    int unsigned                  uuids_completed;
    int unsigned                  plain_bytes;
    int unsigned                  errors;

    function new();
        uuid_mode       = 1'b1;
        pair_pending    = 1'b0;
        first_raw       = 1'b0;
        byte_shift      = '0;
        bit_count       = '0;
        uuid_position   = '0;
        words_predicted = 0;
        words_checked   = 0;
        uuids_completed = 0;
        plain_bytes     = 0;
        errors          = 0;
    endfunction

    // A mode write restarts UUID numbering; pairing and assembly carry on.
    function void write_mode(bit mode);
        uuid_mode     = mode;
        uuid_position = '0;
    endfunction

    function void note_raw_word(bit raw);
        uuid_word_t                 word;
        bit [vnug_pkg::BYTE_W-1:0]  full;
        if (!pair_pending) begin
            first_raw    = raw;
            pair_pending = 1'b1;
            return;
        end
        pair_pending = 1'b0;
        if (first_raw == raw) begin
            return;
        end
        if (bit_count != vnug_pkg::LAST_BIT) begin
            byte_shift = {byte_shift[5:0], raw};
            bit_count  = bit_count + 1'b1;
            return;
        end
        full       = {byte_shift, raw};
        byte_shift = '0;
        bit_count  = '0;
        if (uuid_mode) begin
            if (uuid_position == vnug_pkg::VERSION_BYTE) begin
                full = vnug_pkg::VERSION_BITS | (full & vnug_pkg::VERSION_KEEP);
            end else if (uuid_position == vnug_pkg::VARIANT_BYTE) begin
                full = vnug_pkg::VARIANT_BITS | (full & vnug_pkg::VARIANT_KEEP);
            end
            word.data  = full;
            word.index = uuid_position;
            word.last  = (uuid_position == vnug_pkg::FINAL_BYTE);
            if (word.last) begin
                uuids_completed++;
            end
            uuid_position = uuid_position + 1'b1;
        end else begin
            word.data  = full;
            word.index = '0;
            word.last  = 1'b1;
            plain_bytes++;
        end
        expected_words.push_back(word);
        words_predicted++;
    endfunction

    function void check_result_word(logic [vnug_pkg::BYTE_W-1:0] data,
                                    logic [vnug_pkg::INDEX_W-1:0] index,
                                    logic last);
        uuid_word_t want;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word: byte %h index %0d last %b",
                     $time, data, index, last);
            errors++;
            return;
        end
        want = expected_words.pop_front();
        words_checked++;
        if (data !== want.data) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.data, data);
            errors++;
        end
        if (index !== want.index) begin
            $display("%0t: byte_index mismatch: expected %0d, actual %0d",
                     $time, want.index, index);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: last_byte mismatch: expected %b, actual %b",
                     $time, want.last, last);
            errors++;
        end
    endfunction

    function int unsigned pending();
        return expected_words.size();
    endfunction
endclass

module tb_von_neumann_uuid_generator;

    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT  = 5000;
    localparam int unsigned LONG_HOLD    = 300;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic                         cfg_wr_data = 1'b0;
    logic                         s_valid     = 1'b0;
    logic                         s_ready;
    logic                         s_raw_bit   = 1'b0;
    logic                         m_valid;
    logic                         m_ready     = 1'b0;
    logic [vnug_pkg::BYTE_W-1:0]  m_out_byte;
    logic [vnug_pkg::INDEX_W-1:0] m_byte_index;
    logic                         m_last_byte;

    uuid_byte_scoreboard uuid_sb;

    // Knobs shared between the stimulus and the receiver process, and stimulus counters.
    bit          idle_on       = 1'b1;
    bit          hold_request  = 1'b0;
    int unsigned raw_accepted  = 0;
    int unsigned stall_cycles  = 0;

    always #10 aclk = ~aclk;

    von_neumann_uuid_generator i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_raw_bit    (s_raw_bit),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_index (m_byte_index),
        .m_last_byte  (m_last_byte)
    );

    // Offer one raw word and hold it until the block takes it. On return we
    // sit in the accepting edge's time step with s_valid high, or after an idle gap.
    task automatic send_raw_word(input logic raw);
        s_valid   <= 1'b1;
        s_raw_bit <= raw;
        do begin
            @(posedge aclk);
            if (!s_ready) begin
                stall_cycles++;
            end
        end while (!s_ready);
        uuid_sb.note_raw_word(raw);
        raw_accepted++;
        // Drop valid for a short random gap now and then; every fourth
        // stretch of 50 words runs back to back.
        if (idle_on && ((raw_accepted / 50) % 4 != 3) && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // Mostly clean pairs with random content; a few equal pairs and lone
    // bits that shift the pairing. Runs of all-zero or all-one whitened
    // bits reach the byte extremes.
    task automatic send_random_phase(input int unsigned min_words,
                                     input int unsigned min_results);
        int unsigned sent;
        int unsigned result_base;
        int unsigned pair_count;
        int unsigned bias;
        int unsigned pick;
        logic        white;
        logic        raw;
        sent        = 0;
        result_base = uuid_sb.words_predicted;
        pair_count  = 0;
        bias        = 0;
        while (sent < min_words || uuid_sb.words_predicted - result_base < min_results) begin
            if (pair_count % 16 == 0) begin
                bias = $urandom_range(0, 3);
            end
            pair_count++;
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
                send_raw_word(1'($urandom_range(0, 1)));
                sent += 1;
            end else if (pick < 20) begin
                raw = 1'($urandom_range(0, 1));
                send_raw_word(raw);
                send_raw_word(raw);
                sent += 2;
            end else begin
                case (bias)
                    1: begin
                        white = 1'b0;
                    end
                    2: begin
                        white = 1'b1;
                    end
                    default: begin
                        white = 1'($urandom_range(0, 1));
                    end
                endcase
                send_raw_word(~white);
                send_raw_word(white);
                sent += 2;
            end
        end
        s_valid <= 1'b0;
    endtask

    // Write uuid_mode only once the block has drained: no word in flight
    // and no result left outstanding.
    task automatic write_uuid_mode(input logic mode);
        while (uuid_sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        uuid_sb.write_mode(mode);
    endtask

    // Receiver: check every accepted result word, then pick m_ready for the
    // next edge. The long hold is counted here, in cycles.
    initial begin : result_sink
        int unsigned burst_left;
        int unsigned hold_left;
        int unsigned cycle_count;
        burst_left  = 0;
        hold_left   = 0;
        cycle_count = 0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (m_valid && m_ready) begin
                uuid_sb.check_result_word(m_out_byte, m_byte_index, m_last_byte);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                m_ready <= 1'b0;
            end else if (idle_on && ((cycle_count / 200) % 3 != 2)
                         && $urandom_range(0, 4) == 0) begin
                burst_left = $urandom_range(1, 8) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int unsigned waited;
        uuid_sb = new();

        // Hold reset low, then release.
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one equal pair of each kind is dropped, then eight
        // rising pairs build 0xFF as UUID byte 0 in the reset mode.
        send_raw_word(1'b0);
        send_raw_word(1'b0);
        send_raw_word(1'b1);
        send_raw_word(1'b1);
        repeat (8) begin
            send_raw_word(1'b0);
            send_raw_word(1'b1);
        end

        // UUID mode from reset, with the receiver held off long enough
        // to back the block up and stall its input.
        hold_request = 1'b1;
        send_random_phase(200, 17);

        // Plain bytes.
        write_uuid_mode(1'b0);
        send_random_phase(60, 3);

        // Back to UUIDs, then rewrite the same mode partway through a UUID
        // so the numbering restarts at byte 0.
        write_uuid_mode(1'b1);
        send_random_phase(60, 3);
        write_uuid_mode(1'b1);
        send_random_phase(40, 2);

        // Closing phases: no idling on either side.
        idle_on = 1'b0;
        write_uuid_mode(1'b0);
        send_random_phase(40, 2);
        write_uuid_mode(1'b1);
        send_random_phase(40, 2);

        // Drain: wait for every prediction, bounded, then idle on quiet edges
        // to catch any stray result word.
        waited = 0;
        while (uuid_sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (uuid_sb.pending() != 0) begin
            $display("%0t: %0d predicted result words never arrived",
                     $time, uuid_sb.pending());
            uuid_sb.errors++;
        end

        $display("Covered %0d raw words (%0d input stall cycles) and %0d result words,",
                 raw_accepted, stall_cycles, uuid_sb.words_checked);
        $display("including %0d complete UUIDs and %0d plain bytes; %0d mismatches.",
                 uuid_sb.uuids_completed, uuid_sb.plain_bytes, uuid_sb.errors);
        if (uuid_sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #5ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: von_neumann_uuid_generator.f
hdl/vnug_pkg.sv
hdl/vnug_extract.sv
hdl/vnug_format.sv
hdl/von_neumann_uuid_generator.sv
test/tb_von_neumann_uuid_generator.sv
